### rtl/core/fpce_pkg.sv
// Shared types, codes and helpers for the flash programmer command engine.
// No dependencies; used by fpce_queue, fpce_front, fpce_back and the top level.
package fpce_pkg;

    localparam int OPBUF_DEPTH_DEF = 1024;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [7:0] ACK_BYTE   = 8'h06;
    localparam logic [7:0] NAK_BYTE   = 8'h15;
    localparam logic [7:0] TOP_OPCODE = 8'h10;

    localparam logic [1:0] F_SERIAL = 2'd0;
    localparam logic [1:0] F_FLASH  = 2'd1;
    localparam logic [1:0] F_TICK   = 2'd2;

    localparam logic [1:0] CFG_SBL = 2'd0;
    localparam logic [1:0] CFG_BTM = 2'd1;
    localparam logic [1:0] CFG_CSL = 2'd2;

    localparam logic [2:0] K_SEND  = 3'd0;
    localparam logic [2:0] K_READ  = 3'd1;
    localparam logic [2:0] K_BINIT = 3'd2;
    localparam logic [2:0] K_BREAD = 3'd3;
    localparam logic [2:0] K_ODIS  = 3'd4;
    localparam logic [2:0] K_WRITE = 3'd5;
    localparam logic [2:0] K_DELAY = 3'd6;

    localparam logic [2:0] D_EMIT   = 3'd0;
    localparam logic [2:0] D_SYNC   = 3'd1;
    localparam logic [2:0] D_ACKB   = 3'd2;
    localparam logic [2:0] D_BURST0 = 3'd3;
    localparam logic [2:0] D_BURSTN = 3'd4;
    localparam logic [2:0] D_QUERY  = 3'd5;

    localparam logic [4:0] OP_NOP   = 5'h00;
    localparam logic [4:0] OP_VER   = 5'h01;
    localparam logic [4:0] OP_MAP   = 5'h02;
    localparam logic [4:0] OP_NAME  = 5'h03;
    localparam logic [4:0] OP_SBUF  = 5'h04;
    localparam logic [4:0] OP_BUS   = 5'h05;
    localparam logic [4:0] OP_CHIP  = 5'h06;
    localparam logic [4:0] OP_OPBUF = 5'h07;
    localparam logic [4:0] OP_WNMAX = 5'h08;
    localparam logic [4:0] OP_READ  = 5'h09;
    localparam logic [4:0] OP_READN = 5'h0A;
    localparam logic [4:0] OP_CLEAR = 5'h0B;
    localparam logic [4:0] OP_WBYTE = 5'h0C;
    localparam logic [4:0] OP_WN    = 5'h0D;
    localparam logic [4:0] OP_DELAY = 5'h0E;
    localparam logic [4:0] OP_EXEC  = 5'h0F;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] value;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [23:0] address;
        logic [7:0]  data;
        logic [31:0] delay_us;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  dtype;
        logic [2:0]  kind;
        logic [23:0] address;
        logic [7:0]  data;
        logic [31:0] delay_us;
        logic        flag;
    } desc_t;

    typedef struct packed {
        logic [15:0] sbl;
        logic [7:0]  btm;
        logic [4:0]  csl;
    } cfg_t;

    function automatic logic [2:0] plen(input logic [4:0] op);
        logic [2:0] n;
        unique case (op)
            OP_READ:  n = 3'd3;
            OP_READN: n = 3'd6;
            OP_WBYTE: n = 3'd4;
            OP_DELAY: n = 3'd4;
            default:  n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic desc_t mk_desc(input logic [2:0] dtype, input logic [2:0] kind,
                                      input logic [23:0] addr, input logic [7:0] data,
                                      input logic [31:0] dly, input logic flag);
        desc_t d;
        d.dtype    = dtype;
        d.kind     = kind;
        d.address  = addr;
        d.data     = data;
        d.delay_us = dly;
        d.flag     = flag;
        return d;
    endfunction

    function automatic desc_t mk_send(input logic [7:0] b);
        return mk_desc(D_EMIT, K_SEND, 24'd0, b, 32'd0, 1'b0);
    endfunction

endpackage

### rtl/core/fpce_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fpce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/fpce_queue.sv
// Short request queue between the command front end and the result back end.
// Depends on fpce_pkg.
module fpce_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  fpce_pkg::desc_t push_desc,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output fpce_pkg::desc_t head
);

    localparam int QD = fpce_pkg::QUEUE_DEPTH;
    localparam int PW = $clog2(QD);
    localparam int CW = $clog2(QD + 1);

    fpce_pkg::desc_t   slot_reg [QD];
    logic [PW-1:0]     wp_reg, wp_next, rp_reg, rp_next;
    logic [CW-1:0]     cnt_reg, cnt_next;

    assign full       = cnt_reg == CW'(QD);
    assign head_valid = cnt_reg != '0;
    assign head       = slot_reg[rp_reg];

    always_comb begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wp_next = (wp_reg == PW'(QD - 1)) ? '0 : PW'(wp_reg + 1'b1);
        end
        if (pop) begin
            rp_next = (rp_reg == PW'(QD - 1)) ? '0 : PW'(rp_reg + 1'b1);
        end
        if (push && !pop) begin
            cnt_next = CW'(cnt_reg + 1'b1);
        end else if (pop && !push) begin
            cnt_next = CW'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wp_reg] <= push_desc;
        end
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

### rtl/core/fpce_front.sv
// Front end: accepts requests, parses commands, keeps the operation buffer
// and walks it on exec. Depends on fpce_pkg; drives the fpce_ram ports.
module fpce_front #(
    parameter int OPBUF_DEPTH = fpce_pkg::OPBUF_DEPTH_DEF,
    localparam int AW = $clog2(OPBUF_DEPTH)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  fpce_pkg::in_item_t s_item,
    input  logic               q_full,
    output logic               push,
    output fpce_pkg::desc_t    push_desc,
    output logic               mem_we,
    output logic [AW-1:0]      mem_waddr,
    output logic [7:0]         mem_wdata,
    output logic [AW-1:0]      mem_raddr,
    input  logic [7:0]         mem_rdata
);

    localparam int FW = $clog2(OPBUF_DEPTH + 1);
    localparam int PW = FW + 1;
    localparam logic [FW-1:0] DEPTH_F = FW'(OPBUF_DEPTH);
    localparam logic [PW-1:0] DEPTH_P = PW'(OPBUF_DEPTH);

    localparam logic [3:0] M_IDLE        = 4'd0;
    localparam logic [3:0] M_PARAMS      = 4'd1;
    localparam logic [3:0] M_WN_HDR      = 4'd2;
    localparam logic [3:0] M_WN_BODY     = 4'd3;
    localparam logic [3:0] M_DRAIN       = 4'd4;
    localparam logic [3:0] M_WAIT_SINGLE = 4'd5;
    localparam logic [3:0] M_WAIT_BURST  = 4'd6;
    localparam logic [3:0] M_EXEC_REC    = 4'd7;
    localparam logic [3:0] M_EXEC_DATA   = 4'd8;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_APPEND = 2'd1;
    localparam logic [1:0] S_XREAD  = 2'd2;
    localparam logic [1:0] S_XDATA  = 2'd3;

    logic [3:0]    mode_reg, mode_next;
    logic [4:0]    op_reg, op_next;
    logic [2:0]    pc_reg, pc_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [FW-1:0] ptr_reg, ptr_next;
    logic [24:0]   rem_reg, rem_next;
    logic [23:0]   wa_reg, wa_next;
    logic [1:0]    st_reg, st_next;
    logic [2:0]    k_reg, k_next;
    logic [2:0]    aidx_reg, aidx_next;
    logic [2:0]    alen_reg, alen_next;
    logic          afail_reg, afail_next;
    logic          awn_reg, awn_next;
    logic [7:0]    pb_reg [6];
    logic [7:0]    pb_next [6];
    logic [7:0]    ab_reg [6];
    logic [7:0]    ab_next [6];
    logic [7:0]    xb_reg [5];
    logic [7:0]    xb_next [5];

    logic [7:0]    pbv [6];
    logic [7:0]    b;
    logic          acc;
    logic          act_go;
    logic [4:0]    act_op;
    logic          fin;
    logic [7:0]    fin_byte;
    logic          fail;
    logic [24:0]   rdec;
    logic [23:0]   xaddr;
    logic [PW-1:0] pp;
    logic [PW-1:0] rd_pos;

    function automatic logic [AW-1:0] guard(input logic [PW-1:0] x);
        return (x < DEPTH_P) ? x[AW-1:0] : '0;
    endfunction

    assign s_ready = (st_reg == S_IDLE) && !q_full;
    assign acc     = s_valid && s_ready;
    assign b       = s_item.value;
    assign pp      = PW'(ptr_reg);
    assign rdec    = (rem_reg != '0) ? 25'(rem_reg - 1'b1) : '0;
    assign xaddr   = {xb_reg[4], xb_reg[3], xb_reg[2]};
    assign rd_pos  = (st_reg == S_XREAD) ? PW'(pp + PW'(k_reg)) : pp;
    assign mem_raddr = guard(rd_pos);
    assign fail    = afail_reg || (fill_reg >= DEPTH_F);

    always_comb begin
        pbv = pb_reg;
        if (pc_reg < 3'd6) begin
            pbv[pc_reg] = b;
        end
    end

    always_comb begin
        mode_next  = mode_reg;
        op_next    = op_reg;
        pc_next    = pc_reg;
        fill_next  = fill_reg;
        ptr_next   = ptr_reg;
        rem_next   = rem_reg;
        wa_next    = wa_reg;
        st_next    = st_reg;
        k_next     = k_reg;
        aidx_next  = aidx_reg;
        alen_next  = alen_reg;
        afail_next = afail_reg;
        awn_next   = awn_reg;
        pb_next    = pb_reg;
        ab_next    = ab_reg;
        xb_next    = xb_reg;
        push       = 1'b0;
        push_desc  = '0;
        mem_we     = 1'b0;
        mem_waddr  = fill_reg[AW-1:0];
        mem_wdata  = b;
        act_go     = 1'b0;
        act_op     = op_reg;
        fin        = 1'b0;
        fin_byte   = fpce_pkg::ACK_BYTE;

        unique case (st_reg)
            S_IDLE: begin
                if (acc) begin
                    unique case (s_item.func)
                        fpce_pkg::F_SERIAL: begin
                            unique case (mode_reg)
                                M_IDLE: begin
                                    if (b > fpce_pkg::TOP_OPCODE) begin
                                        push      = 1'b1;
                                        push_desc = fpce_pkg::mk_send(fpce_pkg::NAK_BYTE);
                                    end else begin
                                        op_next = b[4:0];
                                        pc_next = '0;
                                        if (fpce_pkg::plen(b[4:0]) == '0) begin
                                            act_go = 1'b1;
                                            act_op = b[4:0];
                                        end else begin
                                            mode_next = M_PARAMS;
                                        end
                                    end
                                end
                                M_PARAMS: begin
                                    pb_next = pbv;
                                    pc_next = 3'(pc_reg + 1'b1);
                                    if (3'(pc_reg + 1'b1) >= fpce_pkg::plen(op_reg)) begin
                                        act_go = 1'b1;
                                        act_op = op_reg;
                                    end
                                end
                                M_WN_HDR: begin
                                    pb_next = pbv;
                                    pc_next = 3'(pc_reg + 1'b1);
                                    if (pc_reg == 3'd2) begin
                                        rem_next   = (pb_reg[0] == 8'd0) ? 25'd259
                                                   : 25'({1'b0, pb_reg[0]} + 9'd3);
                                        ab_next[0] = 8'h00;
                                        ab_next[1] = pb_reg[0];
                                        alen_next  = 3'd2;
                                        aidx_next  = '0;
                                        afail_next = 1'b0;
                                        awn_next   = 1'b1;
                                        st_next    = S_APPEND;
                                    end
                                end
                                M_WN_BODY: begin
                                    rem_next = rdec;
                                    if (fill_reg < DEPTH_F) begin
                                        mem_we    = 1'b1;
                                        fill_next = FW'(fill_reg + 1'b1);
                                        if (rdec == '0) begin
                                            mode_next = M_IDLE;
                                            push      = 1'b1;
                                            push_desc = fpce_pkg::mk_send(fpce_pkg::ACK_BYTE);
                                        end
                                    end else if (rdec == '0) begin
                                        mode_next = M_IDLE;
                                        push      = 1'b1;
                                        push_desc = fpce_pkg::mk_send(fpce_pkg::NAK_BYTE);
                                    end else begin
                                        mode_next = M_DRAIN;
                                    end
                                end
                                M_DRAIN: begin
                                    rem_next = rdec;
                                    if (rdec == '0) begin
                                        mode_next = M_IDLE;
                                        push      = 1'b1;
                                        push_desc = fpce_pkg::mk_send(fpce_pkg::NAK_BYTE);
                                    end
                                end
                                default: ;
                            endcase
                        end
                        fpce_pkg::F_FLASH: begin
                            if (mode_reg == M_WAIT_SINGLE) begin
                                mode_next = M_IDLE;
                                push      = 1'b1;
                                push_desc = fpce_pkg::mk_desc(fpce_pkg::D_ACKB,
                                    fpce_pkg::K_SEND, 24'd0, b, 32'd0, 1'b0);
                            end else if (mode_reg == M_WAIT_BURST) begin
                                rem_next  = rdec;
                                wa_next   = 24'(wa_reg + 1'b1);
                                push      = 1'b1;
                                push_desc = fpce_pkg::mk_desc(fpce_pkg::D_BURSTN,
                                    fpce_pkg::K_SEND, 24'(wa_reg + 1'b1), b, 32'd0,
                                    rdec == '0);
                                if (rdec == '0) begin
                                    mode_next = M_IDLE;
                                end
                            end
                        end
                        fpce_pkg::F_TICK: begin
                            if (mode_reg == M_EXEC_DATA) begin
                                if (PW'(pp + 1'b1) > PW'(fill_reg)) begin
                                    fin      = 1'b1;
                                    fin_byte = fpce_pkg::NAK_BYTE;
                                end else begin
                                    st_next = S_XDATA;
                                end
                            end else if (mode_reg == M_EXEC_REC) begin
                                if (ptr_reg >= fill_reg) begin
                                    fin = 1'b1;
                                end else begin
                                    st_next = S_XREAD;
                                    k_next  = 3'd1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_APPEND: begin
                mem_wdata = ab_reg[aidx_reg];
                if (fill_reg < DEPTH_F) begin
                    mem_we    = 1'b1;
                    fill_next = FW'(fill_reg + 1'b1);
                end
                afail_next = fail;
                aidx_next  = 3'(aidx_reg + 1'b1);
                if (aidx_reg == 3'(alen_reg - 1'b1)) begin
                    st_next = S_IDLE;
                    if (awn_reg) begin
                        mode_next = fail ? M_DRAIN : M_WN_BODY;
                    end else begin
                        push      = 1'b1;
                        push_desc = fpce_pkg::mk_send(fail ? fpce_pkg::NAK_BYTE
                                                           : fpce_pkg::ACK_BYTE);
                    end
                end
            end
            S_XDATA: begin
                st_next   = S_IDLE;
                push      = 1'b1;
                push_desc = fpce_pkg::mk_desc(fpce_pkg::D_EMIT, fpce_pkg::K_WRITE,
                                              wa_reg, mem_rdata, 32'd0, 1'b0);
                ptr_next  = FW'(ptr_reg + 1'b1);
                wa_next   = 24'(wa_reg + 1'b1);
                rem_next  = rdec;
                if (rdec == '0) begin
                    mode_next = M_EXEC_REC;
                end
            end
            S_XREAD: begin
                if (k_reg != 3'd6) begin
                    xb_next[3'(k_reg - 1'b1)] = mem_rdata;
                    k_next = 3'(k_reg + 1'b1);
                end else begin
                    st_next = S_IDLE;
                    if (PW'(pp + 1'b1) >= PW'(fill_reg)) begin
                        fin      = 1'b1;
                        fin_byte = fpce_pkg::NAK_BYTE;
                    end else if (xb_reg[0] == 8'h00) begin
                        if (PW'(pp + 3'd5) >= PW'(fill_reg)) begin
                            fin      = 1'b1;
                            fin_byte = fpce_pkg::NAK_BYTE;
                        end else begin
                            push      = 1'b1;
                            push_desc = fpce_pkg::mk_desc(fpce_pkg::D_EMIT,
                                fpce_pkg::K_WRITE, xaddr, mem_rdata, 32'd0, 1'b0);
                            wa_next   = 24'(xaddr + 1'b1);
                            ptr_next  = FW'(ptr_reg + 3'd6);
                            rem_next  = (xb_reg[1] == 8'd0) ? 25'd255
                                      : 25'(xb_reg[1] - 1'b1);
                            mode_next = (xb_reg[1] == 8'd1) ? M_EXEC_REC : M_EXEC_DATA;
                        end
                    end else if (xb_reg[0] == 8'h01) begin
                        if (PW'(pp + 3'd5) > PW'(fill_reg)) begin
                            fin      = 1'b1;
                            fin_byte = fpce_pkg::NAK_BYTE;
                        end else begin
                            push      = 1'b1;
                            push_desc = fpce_pkg::mk_desc(fpce_pkg::D_EMIT,
                                fpce_pkg::K_DELAY, 24'd0, 8'd0,
                                {xb_reg[4], xb_reg[3], xb_reg[2], xb_reg[1]}, 1'b0);
                            ptr_next  = FW'(ptr_reg + 3'd5);
                        end
                    end else begin
                        fin      = 1'b1;
                        fin_byte = fpce_pkg::NAK_BYTE;
                    end
                end
            end
            default: ;
        endcase

        if (act_go) begin
            mode_next = M_IDLE;
            unique case (act_op)
                fpce_pkg::OP_NOP: begin
                    push      = 1'b1;
                    push_desc = fpce_pkg::mk_send(fpce_pkg::ACK_BYTE);
                end
                fpce_pkg::OP_VER, fpce_pkg::OP_MAP, fpce_pkg::OP_NAME, fpce_pkg::OP_SBUF,
                fpce_pkg::OP_BUS, fpce_pkg::OP_CHIP, fpce_pkg::OP_OPBUF,
                fpce_pkg::OP_WNMAX: begin
                    push      = 1'b1;
                    push_desc = fpce_pkg::mk_desc(fpce_pkg::D_QUERY, fpce_pkg::K_SEND,
                                                  24'd0, {3'd0, act_op}, 32'd0, 1'b0);
                end
                fpce_pkg::OP_READ: begin
                    wa_next   = {pbv[2], pbv[1], pbv[0]};
                    push      = 1'b1;
                    push_desc = fpce_pkg::mk_desc(fpce_pkg::D_EMIT, fpce_pkg::K_READ,
                                                  {pbv[2], pbv[1], pbv[0]}, 8'd0, 32'd0, 1'b0);
                    mode_next = M_WAIT_SINGLE;
                end
                fpce_pkg::OP_READN: begin
                    wa_next   = {pbv[2], pbv[1], pbv[0]};
                    rem_next  = {1'b0, pbv[5], pbv[4], pbv[3]};
                    push      = 1'b1;
                    push_desc = fpce_pkg::mk_desc(fpce_pkg::D_BURST0, fpce_pkg::K_SEND,
                        {pbv[2], pbv[1], pbv[0]}, 8'd0, 32'd0,
                        {pbv[5], pbv[4], pbv[3]} == 24'd0);
                    if ({pbv[5], pbv[4], pbv[3]} != 24'd0) begin
                        mode_next = M_WAIT_BURST;
                    end
                end
                fpce_pkg::OP_CLEAR: begin
                    fill_next = '0;
                    push      = 1'b1;
                    push_desc = fpce_pkg::mk_send(fpce_pkg::ACK_BYTE);
                end
                fpce_pkg::OP_WBYTE: begin
                    ab_next    = '{8'h00, 8'h01, pbv[0], pbv[1], pbv[2], pbv[3]};
                    alen_next  = 3'd6;
                    aidx_next  = '0;
                    afail_next = 1'b0;
                    awn_next   = 1'b0;
                    st_next    = S_APPEND;
                end
                fpce_pkg::OP_WN: begin
                    pc_next   = '0;
                    mode_next = M_WN_HDR;
                end
                fpce_pkg::OP_DELAY: begin
                    ab_next    = '{8'h01, pbv[0], pbv[1], pbv[2], pbv[3], 8'h00};
                    alen_next  = 3'd5;
                    aidx_next  = '0;
                    afail_next = 1'b0;
                    awn_next   = 1'b0;
                    st_next    = S_APPEND;
                end
                fpce_pkg::OP_EXEC: begin
                    ptr_next = '0;
                    if (fill_reg == '0) begin
                        fin = 1'b1;
                    end else begin
                        mode_next = M_EXEC_REC;
                    end
                end
                default: begin
                    push      = 1'b1;
                    push_desc = fpce_pkg::mk_desc(fpce_pkg::D_SYNC, fpce_pkg::K_SEND,
                                                  24'd0, 8'd0, 32'd0, 1'b0);
                end
            endcase
        end

        if (fin) begin
            fill_next = '0;
            ptr_next  = '0;
            rem_next  = '0;
            mode_next = M_IDLE;
            push      = 1'b1;
            push_desc = fpce_pkg::mk_send(fin_byte);
        end
    end

    always_ff @(posedge aclk) begin
        pb_reg <= pb_next;
        ab_reg <= ab_next;
        xb_reg <= xb_next;
        if (!aresetn) begin
            mode_reg  <= M_IDLE;
            op_reg    <= '0;
            pc_reg    <= '0;
            fill_reg  <= '0;
            ptr_reg   <= '0;
            rem_reg   <= '0;
            wa_reg    <= '0;
            st_reg    <= S_IDLE;
            k_reg     <= '0;
            aidx_reg  <= '0;
            alen_reg  <= '0;
            afail_reg <= 1'b0;
            awn_reg   <= 1'b0;
        end else begin
            mode_reg  <= mode_next;
            op_reg    <= op_next;
            pc_reg    <= pc_next;
            fill_reg  <= fill_next;
            ptr_reg   <= ptr_next;
            rem_reg   <= rem_next;
            wa_reg    <= wa_next;
            st_reg    <= st_next;
            k_reg     <= k_next;
            aidx_reg  <= aidx_next;
            alen_reg  <= alen_next;
            afail_reg <= afail_next;
            awn_reg   <= awn_next;
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= DEPTH_F)
        else $error("operation buffer fill count beyond depth");

    a_exec_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == M_EXEC_REC || mode_reg == M_EXEC_DATA) |-> ptr_reg <= fill_reg)
        else $error("exec pointer past fill count");

    a_push_space: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("request pushed into full queue");

endmodule

### rtl/core/fpce_back.sv
// Back end: expands queued requests into result items, one per cycle while
// m_ready allows, through a registered output stage. Depends on fpce_pkg.
module fpce_back #(
    parameter int OPBUF_DEPTH = fpce_pkg::OPBUF_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  fpce_pkg::cfg_t      cfg,
    input  logic                head_valid,
    input  fpce_pkg::desc_t     head,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output fpce_pkg::out_item_t m_item
);

    localparam logic [15:0] DEPTH16 = 16'(OPBUF_DEPTH);

    logic [5:0]          idx_reg, idx_next;
    logic                ov_reg, ov_next;
    fpce_pkg::out_item_t out_reg, out_next;
    fpce_pkg::out_item_t res;
    logic [5:0]          len;
    logic                load;

    function automatic logic [7:0] name_byte(input logic [5:0] i);
        logic [7:0] v;
        unique case (i)
            6'd0:  v = 8'h06;
            6'd1:  v = 8'h41;
            6'd2:  v = 8'h54;
            6'd3:  v = 8'h4D;
            6'd4:  v = 8'h65;
            6'd5:  v = 8'h67;
            6'd6:  v = 8'h61;
            6'd7:  v = 8'h31;
            6'd8:  v = 8'h36;
            6'd9:  v = 8'h38;
            6'd10: v = 8'h20;
            6'd11: v = 8'h53;
            6'd12: v = 8'h46;
            6'd13: v = 8'h52;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] qbyte(input logic [4:0] op, input logic [5:0] i,
                                         input fpce_pkg::cfg_t c);
        logic [7:0] v;
        v = 8'h00;
        if (i == 6'd0) begin
            v = fpce_pkg::ACK_BYTE;
        end
        unique case (op)
            fpce_pkg::OP_VER:   if (i == 6'd1) v = 8'h01;
            fpce_pkg::OP_MAP:   if (i == 6'd1 || i == 6'd2) v = 8'hFF;
                                else if (i == 6'd3) v = 8'h01;
            fpce_pkg::OP_NAME:  v = name_byte(i);
            fpce_pkg::OP_SBUF:  if (i == 6'd1) v = c.sbl[7:0];
                                else if (i == 6'd2) v = c.sbl[15:8];
            fpce_pkg::OP_BUS:   if (i == 6'd1) v = c.btm;
            fpce_pkg::OP_CHIP:  if (i == 6'd1) v = {3'd0, c.csl};
            fpce_pkg::OP_OPBUF: if (i == 6'd1) v = DEPTH16[7:0];
                                else if (i == 6'd2) v = DEPTH16[15:8];
            fpce_pkg::OP_WNMAX: if (i == 6'd2) v = 8'h01;
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [5:0] qlen(input logic [4:0] op);
        logic [5:0] n;
        unique case (op)
            fpce_pkg::OP_VER:   n = 6'd3;
            fpce_pkg::OP_MAP:   n = 6'd33;
            fpce_pkg::OP_NAME:  n = 6'd17;
            fpce_pkg::OP_SBUF:  n = 6'd3;
            fpce_pkg::OP_BUS:   n = 6'd2;
            fpce_pkg::OP_CHIP:  n = 6'd2;
            fpce_pkg::OP_OPBUF: n = 6'd3;
            fpce_pkg::OP_WNMAX: n = 6'd4;
            default:            n = 6'd1;
        endcase
        return n;
    endfunction

    always_comb begin
        res      = '0;
        res.kind = fpce_pkg::K_SEND;
        len      = 6'd1;
        unique case (head.dtype)
            fpce_pkg::D_SYNC: begin
                len      = 6'd2;
                res.data = (idx_reg == 6'd0) ? fpce_pkg::NAK_BYTE : fpce_pkg::ACK_BYTE;
            end
            fpce_pkg::D_ACKB: begin
                len      = 6'd2;
                res.data = (idx_reg == 6'd0) ? fpce_pkg::ACK_BYTE : head.data;
            end
            fpce_pkg::D_BURST0: begin
                len = 6'd3;
                if (idx_reg == 6'd0) begin
                    res.kind = fpce_pkg::K_BINIT;
                end else if (idx_reg == 6'd1) begin
                    res.data = fpce_pkg::ACK_BYTE;
                end else if (head.flag) begin
                    res.kind = fpce_pkg::K_ODIS;
                end else begin
                    res.kind    = fpce_pkg::K_BREAD;
                    res.address = head.address;
                end
            end
            fpce_pkg::D_BURSTN: begin
                len = 6'd2;
                if (idx_reg == 6'd0) begin
                    res.data = head.data;
                end else if (head.flag) begin
                    res.kind = fpce_pkg::K_ODIS;
                end else begin
                    res.kind    = fpce_pkg::K_BREAD;
                    res.address = head.address;
                end
            end
            fpce_pkg::D_QUERY: begin
                len      = qlen(head.data[4:0]);
                res.data = qbyte(head.data[4:0], idx_reg, cfg);
            end
            default: begin
                res.kind     = head.kind;
                res.address  = head.address;
                res.data     = head.data;
                res.delay_us = head.delay_us;
            end
        endcase
        res.last = idx_reg == 6'(len - 1'b1);
    end

    assign load = head_valid && (!ov_reg || m_ready);
    assign pop  = load && res.last;

    always_comb begin
        idx_next = idx_reg;
        ov_next  = ov_reg;
        out_next = out_reg;
        if (load) begin
            out_next = res;
            ov_next  = 1'b1;
            idx_next = res.last ? 6'd0 : 6'(idx_reg + 1'b1);
        end else if (m_ready) begin
            ov_next = 1'b0;
        end
    end

    assign m_valid = ov_reg;
    assign m_item  = out_reg;

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (!aresetn) begin
            idx_reg <= '0;
            ov_reg  <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            ov_reg  <= ov_next;
        end
    end

endmodule

### rtl/core/flash_programmer_command_engine.sv
// Command engine for a byte-serial parallel flash programmer (top level).
// Depends on fpce_pkg, fpce_ram, fpce_queue, fpce_front and fpce_back.
// Accepted requests pass through the request queue and the registered output stage
// of the back end. Buffer appends and exec ticks hold s_ready low while the buffer
// bytes are written or read, one buffer byte per RAM cycle.
// Results stream at one per cycle unless m_ready stalls them. Synchronous active-low
// reset clears control state and fill count; buffer RAM contents are not cleared.
module flash_programmer_command_engine #(
    parameter int OPBUF_DEPTH = fpce_pkg::OPBUF_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fpce_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output fpce_pkg::out_item_t m_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    localparam int AW = $clog2(OPBUF_DEPTH);

    fpce_pkg::cfg_t  cfg_reg, cfg_next;
    logic            q_full, push, pop, head_valid;
    fpce_pkg::desc_t push_desc, head;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [7:0]      mem_wdata, mem_rdata;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                fpce_pkg::CFG_SBL: cfg_next.sbl = cfg_data;
                fpce_pkg::CFG_BTM: cfg_next.btm = cfg_data[7:0];
                fpce_pkg::CFG_CSL: cfg_next.csl = cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sbl <= 16'd64;
            cfg_reg.btm <= 8'd1;
            cfg_reg.csl <= 5'd18;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    fpce_ram #(
        .WIDTH(8),
        .DEPTH(OPBUF_DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    fpce_front #(
        .OPBUF_DEPTH(OPBUF_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .q_full   (q_full),
        .push     (push),
        .push_desc(push_desc),
        .mem_we   (mem_we),
        .mem_waddr(mem_waddr),
        .mem_wdata(mem_wdata),
        .mem_raddr(mem_raddr),
        .mem_rdata(mem_rdata)
    );

    fpce_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .full      (q_full),
        .pop       (pop),
        .head_valid(head_valid),
        .head      (head)
    );

    fpce_back #(
        .OPBUF_DEPTH(OPBUF_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .head_valid(head_valid),
        .head      (head),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule
